/* sv/lgrs_pkg.sv */
// Shared types, constants and the board mask for the Life row stream.
`timescale 1ns / 1ps

package lgrs_pkg;

  localparam int ROW_W       = 40;
  localparam int BOARD_WIDTH = 40;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    row_t row_bits;
    logic final_row;
  } in_item_t;

  typedef struct packed {
    row_t next_row_bits;
    logic board_done;
  } out_item_t;

  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  function automatic row_t board_mask_f();
    row_t m;
    m = '0;
    for (int c = 0; c < ROW_W; c++) begin
      m[c] = (c < BOARD_WIDTH);
    end
    return m;
  endfunction

  localparam row_t BOARD_MASK = board_mask_f();

endpackage

/* sv/lgrs_rule.sv */
// Next-generation rule B3/S23 for one row from its row above and row below.
`timescale 1ns / 1ps

module lgrs_rule (
  input  lgrs_pkg::row_t above,
  input  lgrs_pkg::row_t mid,
  input  lgrs_pkg::row_t below,
  output lgrs_pkg::row_t next_row
);

  logic [lgrs_pkg::ROW_W+1:0] above_x;
  logic [lgrs_pkg::ROW_W+1:0] mid_x;
  logic [lgrs_pkg::ROW_W+1:0] below_x;
  lgrs_pkg::row_t             gen_row;

  assign above_x = {1'b0, above & lgrs_pkg::BOARD_MASK, 1'b0};
  assign mid_x   = {1'b0, mid & lgrs_pkg::BOARD_MASK, 1'b0};
  assign below_x = {1'b0, below & lgrs_pkg::BOARD_MASK, 1'b0};

  always_comb begin
    logic [3:0] n;
    gen_row = '0;
    for (int c = 0; c < lgrs_pkg::ROW_W; c++) begin
      n = 4'(above_x[c]) + 4'(above_x[c+1]) + 4'(above_x[c+2])
        + 4'(mid_x[c])   + 4'(mid_x[c+2])
        + 4'(below_x[c]) + 4'(below_x[c+1]) + 4'(below_x[c+2]);
      gen_row[c] = (n == 4'd3) || ((n == 4'd2) && mid_x[c+1]);
    end
  end

  assign next_row = gen_row & lgrs_pkg::BOARD_MASK;

endmodule

/* sv/lgrs_window.sv */
// Row window state and the results that each accepted row produces.
`timescale 1ns / 1ps

module lgrs_window (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  lgrs_pkg::in_item_t in_item,
  output lgrs_pkg::push_t    push
);

  lgrs_pkg::row_t row_two_back_r, row_two_back_nxt;
  lgrs_pkg::row_t row_one_back_r, row_one_back_nxt;
  logic           have_prior_row_r, have_prior_row_nxt;

  lgrs_pkg::row_t row_in;
  lgrs_pkg::row_t gen_a_above, gen_a_mid, gen_a_below, gen_a_row;
  lgrs_pkg::row_t gen_b_row;

  assign row_in = in_item.row_bits & lgrs_pkg::BOARD_MASK;

  assign gen_a_above = have_prior_row_r ? row_two_back_r : '0;
  assign gen_a_mid   = have_prior_row_r ? row_one_back_r : row_in;
  assign gen_a_below = have_prior_row_r ? row_in : '0;

  lgrs_rule u_rule_a (
    .above    (gen_a_above),
    .mid      (gen_a_mid),
    .below    (gen_a_below),
    .next_row (gen_a_row)
  );

  lgrs_rule u_rule_b (
    .above    (row_one_back_r),
    .mid      (row_in),
    .below    ('0),
    .next_row (gen_b_row)
  );

  always_comb begin
    push.first.next_row_bits  = gen_a_row;
    push.first.board_done     = !have_prior_row_r;
    push.second.next_row_bits = gen_b_row;
    push.second.board_done    = 1'b1;
    push.count                = lgrs_pkg::PUSH_NONE;
    row_two_back_nxt          = row_two_back_r;
    row_one_back_nxt          = row_one_back_r;
    have_prior_row_nxt        = have_prior_row_r;
    if (accept) begin
      if (in_item.final_row) begin
        push.count         = have_prior_row_r ? lgrs_pkg::PUSH_TWO : lgrs_pkg::PUSH_ONE;
        row_two_back_nxt   = '0;
        row_one_back_nxt   = '0;
        have_prior_row_nxt = 1'b0;
      end else begin
        push.count         = have_prior_row_r ? lgrs_pkg::PUSH_ONE : lgrs_pkg::PUSH_NONE;
        row_two_back_nxt   = have_prior_row_r ? row_one_back_r : '0;
        row_one_back_nxt   = row_in;
        have_prior_row_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_two_back_r   <= '0;
      row_one_back_r   <= '0;
      have_prior_row_r <= 1'b0;
    end else begin
      row_two_back_r   <= row_two_back_nxt;
      row_one_back_r   <= row_one_back_nxt;
      have_prior_row_r <= have_prior_row_nxt;
    end
  end

  // A bottom row always leaves the window empty for the next board.
  a_final_clears : assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.final_row |=> !have_prior_row_r && row_one_back_r == '0)
    else $error("window not cleared after bottom row");

  // Two results come only from a bottom row that follows a pending row.
  a_two_needs_prior : assert property (@(posedge clk) disable iff (!rst_n)
    push.count == lgrs_pkg::PUSH_TWO |-> accept && in_item.final_row && have_prior_row_r)
    else $error("double result without pending row");

endmodule

/* sv/lgrs_out_fifo.sv */
// Small result queue that takes up to two results per cycle and releases one.
`timescale 1ns / 1ps

module lgrs_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  lgrs_pkg::push_t     push,
  input  logic                pop,
  output logic                has_room,
  output logic                not_empty,
  output lgrs_pkg::out_item_t head
);

  lgrs_pkg::out_item_t mem_r [lgrs_pkg::FIFO_DEPTH];

  logic [lgrs_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lgrs_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lgrs_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [lgrs_pkg::PTR_W-1:0] wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr_r + lgrs_pkg::PTR_W'(1);
  assign has_room     = count_r <= lgrs_pkg::CNT_W'(lgrs_pkg::FIFO_DEPTH - 2);
  assign not_empty    = count_r != '0;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + lgrs_pkg::PTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + lgrs_pkg::PTR_W'(pop);
    count_nxt  = count_r + lgrs_pkg::CNT_W'(push.count) - lgrs_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != lgrs_pkg::PUSH_NONE) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == lgrs_pkg::PUSH_TWO) begin
      mem_r[wr_ptr_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // The fill level never passes the queue depth.
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= lgrs_pkg::CNT_W'(lgrs_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // The fill level and the pointers stay consistent.
  a_ptr_match : assert property (@(posedge clk) disable iff (!rst_n)
    lgrs_pkg::PTR_W'(rd_ptr_r + lgrs_pkg::PTR_W'(count_r)) == wr_ptr_r)
    else $error("result queue pointers disagree with count");

endmodule

/* sv/life_generation_row_stream.sv */
// Top level of the Life B3/S23 row stream: one board row in, next-state rows out.
// A result enters the result queue as the row that completes it transfers, and is offered at the queue head.
// Throughput: one row per cycle while in_ready is high; a bottom row that follows a pending
// row yields two results, which enter a four-entry result queue together and leave it singly.
// Input ready depends only on the queue fill level (at most two entries in use).
// Reset (synchronous, rst_n low) empties the row window and the result queue.
`timescale 1ns / 1ps

module life_generation_row_stream (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lgrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lgrs_pkg::out_item_t out_data
);

  logic            accept;
  logic            pop;
  lgrs_pkg::push_t push;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;

  lgrs_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .push    (push)
  );

  lgrs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .has_room  (in_ready),
    .not_empty (out_valid),
    .head      (out_data)
  );

endmodule
